// File: sv/urlc_pkg.sv
// Shared types and codes for the USB rate lease controller.
// Holds the request and result word layouts, the register map and the command codes.
// No dependencies.
package urlc_pkg;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	localparam logic [1:0] REG_REENUM_DELAY  = 2'd0;
	localparam logic [1:0] REG_LEASE_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_NEUTRAL_DELAY = 2'd2;

	localparam logic [15:0] REENUM_DELAY_RST  = 16'd100;
	localparam logic [15:0] LEASE_TIMEOUT_RST = 16'd500;
	localparam logic [15:0] NEUTRAL_DELAY_RST = 16'd20;

	localparam logic [15:0] NATIVE_RATE_HZ = 16'd1000;
	localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

	localparam logic [2:0] CMD_CONTROL = 3'd0;
	localparam logic [2:0] CMD_TICK    = 3'd1;
	localparam logic [2:0] CMD_NEUTRAL = 3'd2;
	localparam logic [2:0] CMD_FAULT   = 3'd3;
	localparam logic [2:0] CMD_SUBMIT  = 3'd4;
	localparam logic [2:0] CMD_COMMIT  = 3'd5;

	localparam logic [7:0] OP_QUERY     = 8'd0;
	localparam logic [7:0] OP_ACQUIRE   = 8'd1;
	localparam logic [7:0] OP_HEARTBEAT = 8'd2;
	localparam logic [7:0] OP_RELEASE   = 8'd3;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_BAD_CRC     = 3'd1;
	localparam logic [2:0] ST_BAD_VERSION = 3'd2;
	localparam logic [2:0] ST_BUSY        = 3'd3;
	localparam logic [2:0] ST_BAD_STATE   = 3'd4;
	localparam logic [2:0] ST_BAD_TOKEN   = 3'd5;

	localparam logic [2:0] EV_NONE          = 3'd0;
	localparam logic [2:0] EV_SEND_NEUTRAL  = 3'd1;
	localparam logic [2:0] EV_DETACH_TURBO  = 3'd2;
	localparam logic [2:0] EV_ATTACH_TURBO  = 3'd3;
	localparam logic [2:0] EV_DETACH_NATIVE = 3'd4;
	localparam logic [2:0] EV_ATTACH_NATIVE = 3'd5;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] now_ms;
		logic [7:0]  opcode;
		logic        frame_ok;
		logic        version_ok;
		logic [63:0] token_low;
		logic [63:0] token_high;
		logic        high_speed;
		logic        from_turbo;
		logic [15:0] board_rate_hz;
		logic        action_zero;
		logic        battery_valid;
	} req_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  event_res;
		logic [3:0]  mode_flags;
		logic [15:0] rate_hz;
		logic [31:0] sequence_res;
		logic [3:0]  packet_flags;
		logic        packet_made;
		logic [15:0] overwrite_count;
		logic [15:0] fault_count;
		logic [63:0] lease_low;
		logic [63:0] lease_high;
	} rsp_word_t;

	typedef struct packed {
		logic [15:0] reenum_delay_ms;
		logic [15:0] lease_timeout_ms;
		logic [15:0] neutral_delay_ms;
	} cfg_t;

endpackage

// File: sv/urlc_lease_fsm.sv
// Lease state, counters and token store, with the next-state and result logic for one word.
// Depends on urlc_pkg for word layouts, codes and configuration struct.
module urlc_lease_fsm
	import urlc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  req_word_t item,
	input  cfg_t      cfg,
	output rsp_word_t result
);

	localparam logic [2:0] MODE_NATIVE       = 3'd0;
	localparam logic [2:0] MODE_ARMING       = 3'd1;
	localparam logic [2:0] MODE_DET_TURBO    = 3'd2;
	localparam logic [2:0] MODE_TURBO_WAIT   = 3'd3;
	localparam logic [2:0] MODE_TURBO_ACTIVE = 3'd4;
	localparam logic [2:0] MODE_FALLBACK     = 3'd5;
	localparam logic [2:0] MODE_DET_NATIVE   = 3'd6;

	logic [2:0]  mode_q, mode_d;
	logic [63:0] tok_lo_q, tok_lo_d;
	logic [63:0] tok_hi_q, tok_hi_d;
	logic [31:0] deadline_q, deadline_d;
	logic [31:0] last_hb_q, last_hb_d;
	logic [31:0] seq_q, seq_d;
	logic [15:0] rate_q, rate_d;
	logic [15:0] overwrites_q, overwrites_d;
	logic [15:0] faults_q, faults_d;
	logic        pkt_pend_q, pkt_pend_d;
	logic        neu_pend_q, neu_pend_d;
	logic        speed_q, speed_d;

	logic        match;
	logic        deadline_hit;
	logic        hb_timeout;
	logic [31:0] reenum_at;
	logic        clear_lease;
	logic [2:0]  status;
	logic [2:0]  event_res;
	logic [31:0] seq_out;
	logic [3:0]  pflags;
	logic        made;

	assign match        = (item.token_low == tok_lo_q) && (item.token_high == tok_hi_q);
	// wrap-safe: reached once the signed distance is non-negative
	assign deadline_hit = ~(item.now_ms - deadline_q) >> 31 == 32'd1;
	assign hb_timeout   = (item.now_ms - last_hb_q) >= {16'd0, cfg.lease_timeout_ms};
	assign reenum_at    = item.now_ms + {16'd0, cfg.reenum_delay_ms};

	always_comb begin
		mode_d       = mode_q;
		tok_lo_d     = tok_lo_q;
		tok_hi_d     = tok_hi_q;
		deadline_d   = deadline_q;
		last_hb_d    = last_hb_q;
		seq_d        = seq_q;
		rate_d       = rate_q;
		overwrites_d = overwrites_q;
		faults_d     = faults_q;
		pkt_pend_d   = pkt_pend_q;
		neu_pend_d   = neu_pend_q;
		speed_d      = speed_q;
		clear_lease  = 1'b0;
		status       = ST_OK;
		event_res    = EV_NONE;
		seq_out      = 32'd0;
		pflags       = 4'd0;
		made         = 1'b0;

		case (item.cmd)
			CMD_CONTROL: begin
				speed_d = item.high_speed;
				if (!item.frame_ok) begin
					status = ST_BAD_CRC;
				end else if (!item.version_ok) begin
					status = ST_BAD_VERSION;
				end else begin
					case (item.opcode)
						OP_QUERY: status = ST_OK;
						OP_ACQUIRE: begin
							if (item.from_turbo || mode_q != MODE_NATIVE) begin
								status = ST_BUSY;
							end else if (!item.high_speed || rate_q <= NATIVE_RATE_HZ ||
									(item.token_low == 64'd0 && item.token_high == 64'd0)) begin
								status = ST_BAD_STATE;
							end else begin
								tok_lo_d     = item.token_low;
								tok_hi_d     = item.token_high;
								mode_d       = MODE_ARMING;
								deadline_d   = 32'd0;
								neu_pend_d   = 1'b1;
								pkt_pend_d   = 1'b0;
								overwrites_d = 16'd0;
								faults_d     = 16'd0;
								seq_d        = 32'd0;
							end
						end
						OP_HEARTBEAT: begin
							if (!item.from_turbo ||
									!(mode_q inside {MODE_TURBO_WAIT, MODE_TURBO_ACTIVE})) begin
								status = ST_BAD_STATE;
							end else if (!match) begin
								status = ST_BAD_TOKEN;
							end else begin
								mode_d    = MODE_TURBO_ACTIVE;
								last_hb_d = item.now_ms;
							end
						end
						OP_RELEASE: begin
							if (mode_q == MODE_NATIVE) begin
								status = ST_BAD_STATE;
							end else if (!match) begin
								status = ST_BAD_TOKEN;
							end else if (mode_q == MODE_ARMING && !item.from_turbo) begin
								clear_lease = 1'b1;
							end else begin
								mode_d     = MODE_FALLBACK;
								pkt_pend_d = 1'b0;
							end
						end
						default: status = ST_BAD_STATE;
					endcase
				end
			end
			CMD_TICK: begin
				if (neu_pend_q) begin
					event_res = EV_SEND_NEUTRAL;
				end else begin
					case (mode_q)
						MODE_ARMING: begin
							if (deadline_hit) begin
								mode_d     = MODE_DET_TURBO;
								deadline_d = reenum_at;
								event_res  = EV_DETACH_TURBO;
							end
						end
						MODE_DET_TURBO: begin
							if (deadline_hit) begin
								mode_d    = MODE_TURBO_WAIT;
								last_hb_d = item.now_ms;
								event_res = EV_ATTACH_TURBO;
							end
						end
						MODE_TURBO_WAIT, MODE_TURBO_ACTIVE: begin
							if (hb_timeout) begin
								mode_d     = MODE_DET_NATIVE;
								deadline_d = reenum_at;
								pkt_pend_d = 1'b0;
								event_res  = EV_DETACH_NATIVE;
							end
						end
						MODE_FALLBACK: begin
							mode_d     = MODE_DET_NATIVE;
							deadline_d = reenum_at;
							pkt_pend_d = 1'b0;
							event_res  = EV_DETACH_NATIVE;
						end
						MODE_DET_NATIVE: begin
							if (deadline_hit) begin
								clear_lease = 1'b1;
								event_res   = EV_ATTACH_NATIVE;
							end
						end
						default: event_res = EV_NONE;
					endcase
				end
			end
			CMD_NEUTRAL: begin
				if (mode_q == MODE_ARMING && neu_pend_q) begin
					neu_pend_d = 1'b0;
					deadline_d = item.now_ms + {16'd0, cfg.neutral_delay_ms};
				end
			end
			CMD_FAULT: begin
				if (faults_q != COUNT_MAX) faults_d = faults_q + 16'd1;
			end
			CMD_SUBMIT: begin
				rate_d = item.board_rate_hz;
				if (mode_q == MODE_TURBO_ACTIVE) begin
					pflags[0] = 1'b1;
					if (pkt_pend_q) begin
						if (overwrites_q != COUNT_MAX) overwrites_d = overwrites_q + 16'd1;
						pflags[1] = 1'b1;
					end
					pflags[2]  = item.battery_valid;
					pflags[3]  = item.action_zero;
					seq_out    = seq_q;
					seq_d      = seq_q + 32'd1;
					pkt_pend_d = 1'b1;
					made       = 1'b1;
				end
			end
			CMD_COMMIT: pkt_pend_d = 1'b0;
			default: mode_d = mode_q;
		endcase

		// teardown returns the whole lease to its reset picture
		if (clear_lease) begin
			mode_d       = MODE_NATIVE;
			tok_lo_d     = 64'd0;
			tok_hi_d     = 64'd0;
			deadline_d   = 32'd0;
			last_hb_d    = 32'd0;
			seq_d        = 32'd0;
			rate_d       = NATIVE_RATE_HZ;
			overwrites_d = 16'd0;
			faults_d     = 16'd0;
			pkt_pend_d   = 1'b0;
			neu_pend_d   = 1'b0;
			speed_d      = 1'b0;
		end
	end

	always_comb begin
		result.status          = status;
		result.event_res       = event_res;
		result.mode_flags[0]   = mode_d != MODE_NATIVE;
		result.mode_flags[1]   = mode_d == MODE_TURBO_ACTIVE;
		result.mode_flags[2]   = speed_d;
		result.mode_flags[3]   = mode_d inside {MODE_FALLBACK, MODE_DET_NATIVE};
		result.rate_hz         = rate_d;
		result.sequence_res    = seq_out;
		result.packet_flags    = pflags;
		result.packet_made     = made;
		result.overwrite_count = overwrites_d;
		result.fault_count     = faults_d;
		result.lease_low       = tok_lo_d;
		result.lease_high      = tok_hi_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_NATIVE;
			tok_lo_q     <= 64'd0;
			tok_hi_q     <= 64'd0;
			deadline_q   <= 32'd0;
			last_hb_q    <= 32'd0;
			seq_q        <= 32'd0;
			rate_q       <= NATIVE_RATE_HZ;
			overwrites_q <= 16'd0;
			faults_q     <= 16'd0;
			pkt_pend_q   <= 1'b0;
			neu_pend_q   <= 1'b0;
			speed_q      <= 1'b0;
		end else if (step) begin
			mode_q       <= mode_d;
			tok_lo_q     <= tok_lo_d;
			tok_hi_q     <= tok_hi_d;
			deadline_q   <= deadline_d;
			last_hb_q    <= last_hb_d;
			seq_q        <= seq_d;
			rate_q       <= rate_d;
			overwrites_q <= overwrites_d;
			faults_q     <= faults_d;
			pkt_pend_q   <= pkt_pend_d;
			neu_pend_q   <= neu_pend_d;
			speed_q      <= speed_d;
		end
	end

endmodule

// File: sv/usb_rate_lease_controller.sv
// USB rate lease controller: a request word enters an input register, the lease logic
// updates its state and builds the result word combinationally; the result waits in an
// output register. One word per cycle is sustained whenever the result side takes words;
// a word held in the input register moves on only while the output register is free or
// being drained. The rate is set by the update of the lease state, which each word reads
// and writes in turn.
// Configuration is an APB-style port: byte addresses 0, 4 and 8 hold the reattach delay,
// the heartbeat lease timeout and the post-neutral delay, each 16 bits.
// Depends on urlc_pkg and urlc_lease_fsm.
module usb_rate_lease_controller
	import urlc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  req_word_t         req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rsp_word_t         rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t      cfg_q;
	logic      req_valid_s1;
	req_word_t req_s1;
	logic      rsp_valid_s2;
	rsp_word_t rsp_s2;
	logic      advance;
	logic      cfg_wr;
	rsp_word_t result;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reenum_delay_ms  <= REENUM_DELAY_RST;
			cfg_q.lease_timeout_ms <= LEASE_TIMEOUT_RST;
			cfg_q.neutral_delay_ms <= NEUTRAL_DELAY_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_REENUM_DELAY:  cfg_q.reenum_delay_ms  <= pwdata[15:0];
				REG_LEASE_TIMEOUT: cfg_q.lease_timeout_ms <= pwdata[15:0];
				REG_NEUTRAL_DELAY: cfg_q.neutral_delay_ms <= pwdata[15:0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_REENUM_DELAY:  prdata = {16'd0, cfg_q.reenum_delay_ms};
			REG_LEASE_TIMEOUT: prdata = {16'd0, cfg_q.lease_timeout_ms};
			REG_NEUTRAL_DELAY: prdata = {16'd0, cfg_q.neutral_delay_ms};
			default:           prdata = '0;
		endcase
	end

	// move the held word on whenever the output register is free or being drained
	assign advance   = req_valid_s1 && (!rsp_valid_s2 || rsp_ready);
	assign req_ready = !req_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			rsp_valid_s2 <= 1'b0;
		end else begin
			if (req_valid && req_ready) req_valid_s1 <= 1'b1;
			else if (advance) req_valid_s1 <= 1'b0;
			if (advance) rsp_valid_s2 <= 1'b1;
			else if (rsp_ready) rsp_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) req_s1 <= req;
		if (advance) rsp_s2 <= result;
	end

	urlc_lease_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (req_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	assign rsp_valid = rsp_valid_s2;
	assign rsp       = rsp_s2;

endmodule

// File: sv/urlc_checker.sv
// Port-level checks for the USB rate lease controller, attached by bind.
// Depends on urlc_pkg and the top level usb_rate_lease_controller.
module urlc_checker
	import urlc_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input rsp_word_t rsp
);

	// hold a stalled result word
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result word changed while stalled");

	// only a tick raises an event, only a control request carries a status
	a_event_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.event_res != EV_NONE |-> rsp.status == ST_OK)
		else $error("event and non-ok status in one word");

	// packets are built only while turbo is active
	a_packet_mode: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.packet_made |->
			rsp.packet_flags[0] && rsp.mode_flags[1:0] == 2'b11 && !rsp.mode_flags[3])
		else $error("packet built outside turbo active");

	a_no_packet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.packet_made |-> rsp.packet_flags == 4'd0 && rsp.sequence_res == 32'd0)
		else $error("packet fields set without a packet");

	// native mode never holds a lease token
	a_native_token: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.mode_flags[0] |-> rsp.lease_low == 64'd0 && rsp.lease_high == 64'd0)
		else $error("lease token held in native mode");

endmodule

bind usb_rate_lease_controller urlc_checker u_urlc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

// File: test/tb_usb_rate_lease_controller.sv
`timescale 1ns / 100ps
// Self-checking testbench for usb_rate_lease_controller: a directed table, then random
// lease sessions under three idling regimes, then a short packet and fault burst.
// Depends on urlc_pkg and the controller RTL.
module tb_usb_rate_lease_controller;
	import urlc_pkg::*;

	localparam int unsigned STALL_LIMIT = 20000;
	localparam logic [63:0] ALL_ONES = '1;

	typedef enum logic [2:0] {
		M_NATIVE, M_ARMING, M_DET_TURBO, M_TURBO_WAIT, M_TURBO_ACTIVE, M_FALLBACK, M_DET_NATIVE
	} lease_mode_e;

	typedef struct {
		req_word_t   w;
		bit          typed;
		logic [2:0]  status;
		logic [2:0]  event_res;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_word_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_word_t rsp;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	// predictor copy of the register file and lease state
	logic [15:0] cfg_reenum = REENUM_DELAY_RST;
	logic [15:0] cfg_timeout = LEASE_TIMEOUT_RST;
	logic [15:0] cfg_neutral = NEUTRAL_DELAY_RST;
	lease_mode_e lease_mode;
	logic [63:0] lease_lo, lease_hi;
	logic [31:0] deadline, last_beat, stream_seq;
	logic [15:0] held_rate, overwrites, link_faults;
	bit packet_pending, neutral_pending, speed_latched;

	rsp_word_t awaited_rsp[$];
	plan_row_t directed_rows[$];
	logic [31:0] clock_ms = '0;
	int unsigned snd_idle_pct = 24;
	int unsigned rcv_idle_pct = 50;
	int unsigned mismatches = 0;
	int unsigned words_seen = 0;
	int unsigned quiet_cycles = 0;

	usb_rate_lease_controller dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic void lease_clear();
		lease_mode = M_NATIVE;
		lease_lo = '0;
		lease_hi = '0;
		deadline = '0;
		last_beat = '0;
		stream_seq = '0;
		held_rate = NATIVE_RATE_HZ;
		overwrites = '0;
		link_faults = '0;
		packet_pending = 0;
		neutral_pending = 0;
		speed_latched = 0;
	endfunction

	function automatic rsp_word_t lease_predict(input req_word_t w);
		rsp_word_t r;
		bit tok_match;
		logic [31:0] since_deadline, since_beat;
		r = '0;
		tok_match = (w.token_low == lease_lo) && (w.token_high == lease_hi);
		since_deadline = w.now_ms - deadline;
		since_beat = w.now_ms - last_beat;
		case (w.cmd)
			CMD_CONTROL: begin
				speed_latched = w.high_speed;
				if (!w.frame_ok) r.status = ST_BAD_CRC;
				else if (!w.version_ok) r.status = ST_BAD_VERSION;
				else case (w.opcode)
					OP_QUERY: r.status = ST_OK;
					OP_ACQUIRE: begin
						if (w.from_turbo || lease_mode != M_NATIVE) r.status = ST_BUSY;
						else if (!w.high_speed || held_rate <= NATIVE_RATE_HZ
								|| {w.token_high, w.token_low} == '0) r.status = ST_BAD_STATE;
						else begin
							lease_lo = w.token_low;
							lease_hi = w.token_high;
							lease_mode = M_ARMING;
							deadline = '0;
							neutral_pending = 1;
							packet_pending = 0;
							overwrites = '0;
							link_faults = '0;
							stream_seq = '0;
							r.status = ST_OK;
						end
					end
					OP_HEARTBEAT: begin
						if (!w.from_turbo || !(lease_mode == M_TURBO_WAIT
								|| lease_mode == M_TURBO_ACTIVE)) r.status = ST_BAD_STATE;
						else if (!tok_match) r.status = ST_BAD_TOKEN;
						else begin
							lease_mode = M_TURBO_ACTIVE;
							last_beat = w.now_ms;
							r.status = ST_OK;
						end
					end
					OP_RELEASE: begin
						if (lease_mode == M_NATIVE) r.status = ST_BAD_STATE;
						else if (!tok_match) r.status = ST_BAD_TOKEN;
						else begin
							if (lease_mode == M_ARMING && !w.from_turbo) lease_clear();
							else begin
								lease_mode = M_FALLBACK;
								packet_pending = 0;
							end
							r.status = ST_OK;
						end
					end
					default: r.status = ST_BAD_STATE;
				endcase
			end
			CMD_TICK: begin
				if (neutral_pending) r.event_res = EV_SEND_NEUTRAL;
				else case (lease_mode)
					M_ARMING: if (!since_deadline[31]) begin
						lease_mode = M_DET_TURBO;
						deadline = w.now_ms + {16'h0, cfg_reenum};
						r.event_res = EV_DETACH_TURBO;
					end
					M_DET_TURBO: if (!since_deadline[31]) begin
						lease_mode = M_TURBO_WAIT;
						last_beat = w.now_ms;
						r.event_res = EV_ATTACH_TURBO;
					end
					M_TURBO_WAIT, M_TURBO_ACTIVE: if (since_beat >= {16'h0, cfg_timeout}) begin
						lease_mode = M_DET_NATIVE;
						deadline = w.now_ms + {16'h0, cfg_reenum};
						packet_pending = 0;
						r.event_res = EV_DETACH_NATIVE;
					end
					M_FALLBACK: begin
						lease_mode = M_DET_NATIVE;
						deadline = w.now_ms + {16'h0, cfg_reenum};
						packet_pending = 0;
						r.event_res = EV_DETACH_NATIVE;
					end
					M_DET_NATIVE: if (!since_deadline[31]) begin
						lease_clear();
						r.event_res = EV_ATTACH_NATIVE;
					end
					default: ;
				endcase
			end
			CMD_NEUTRAL: if (lease_mode == M_ARMING && neutral_pending) begin
				neutral_pending = 0;
				deadline = w.now_ms + {16'h0, cfg_neutral};
			end
			CMD_FAULT: if (link_faults != COUNT_MAX) link_faults++;
			CMD_SUBMIT: begin
				held_rate = w.board_rate_hz;
				if (lease_mode == M_TURBO_ACTIVE) begin
					r.packet_flags[0] = 1'b1;
					if (packet_pending) begin
						if (overwrites != COUNT_MAX) overwrites++;
						r.packet_flags[1] = 1'b1;
					end
					r.packet_flags[2] = w.battery_valid;
					r.packet_flags[3] = w.action_zero;
					r.sequence_res = stream_seq;
					stream_seq++;
					packet_pending = 1;
					r.packet_made = 1'b1;
				end
			end
			CMD_COMMIT: packet_pending = 0;
			default: ;
		endcase
		r.mode_flags = {lease_mode == M_FALLBACK || lease_mode == M_DET_NATIVE,
			speed_latched, lease_mode == M_TURBO_ACTIVE, lease_mode != M_NATIVE};
		r.rate_hz = held_rate;
		r.overwrite_count = overwrites;
		r.fault_count = link_faults;
		r.lease_low = lease_lo;
		r.lease_high = lease_hi;
		return r;
	endfunction

	function automatic req_word_t ctl_word(input logic [7:0] op, input bit frame, input bit ver,
			input bit hs, input bit turbo, input logic [63:0] tlo, input logic [63:0] thi,
			input logic [31:0] now);
		req_word_t w;
		w = '0;
		w.cmd = CMD_CONTROL;
		w.opcode = op;
		w.frame_ok = frame;
		w.version_ok = ver;
		w.high_speed = hs;
		w.from_turbo = turbo;
		w.token_low = tlo;
		w.token_high = thi;
		w.now_ms = now;
		return w;
	endfunction

	function automatic req_word_t evt_word(input logic [2:0] cmd, input logic [31:0] now,
			input logic [15:0] rate, input bit az, input bit bv);
		req_word_t w;
		w = '0;
		w.cmd = cmd;
		w.now_ms = now;
		w.board_rate_hz = rate;
		w.action_zero = az;
		w.battery_valid = bv;
		return w;
	endfunction

	// Mostly follow the lease through its modes with random content; steer keeps to the
	// path that leads into turbo active.
	function automatic req_word_t next_item(input bit steer);
		req_word_t w;
		int unsigned pick;
		int jitter;
		w.cmd = 3'($urandom_range(7));
		w.now_ms = $urandom;
		w.opcode = 8'($urandom_range(255));
		w.frame_ok = 1'($urandom_range(1));
		w.version_ok = 1'($urandom_range(1));
		w.token_low = {$urandom, $urandom};
		w.token_high = {$urandom, $urandom};
		w.high_speed = 1'($urandom_range(1));
		w.from_turbo = 1'($urandom_range(1));
		w.board_rate_hz = 16'($urandom_range(65535));
		w.action_zero = 1'($urandom_range(1));
		w.battery_valid = 1'($urandom_range(1));
		if (!steer && $urandom_range(99) < 15) return w;
		w.frame_ok = 1'b1;
		w.version_ok = 1'b1;
		w.now_ms = clock_ms + $urandom_range(30);
		pick = $urandom_range(99);
		jitter = steer ? int'($urandom_range(4)) : int'($urandom_range(12)) - 6;
		case (lease_mode)
			M_NATIVE: begin
				if (held_rate <= NATIVE_RATE_HZ || pick < 15) begin
					w.cmd = CMD_SUBMIT;
					if (steer || pick >= 4) w.board_rate_hz = 16'($urandom_range(65535, 1001));
				end else begin
					w.cmd = CMD_CONTROL;
					w.opcode = OP_ACQUIRE;
					w.high_speed = 1'b1;
					w.from_turbo = 1'b0;
					w.token_low[0] = 1'b1;
				end
			end
			M_ARMING: begin
				if (neutral_pending && (steer || pick < 60)) w.cmd = CMD_NEUTRAL;
				else if (steer || pick < 88) begin
					w.cmd = CMD_TICK;
					if (!neutral_pending) w.now_ms = deadline + 32'(jitter);
				end else begin
					w.cmd = CMD_CONTROL;
					w.opcode = OP_RELEASE;
					w.token_low = lease_lo;
					w.token_high = lease_hi;
				end
			end
			M_DET_TURBO, M_DET_NATIVE, M_FALLBACK: begin
				w.cmd = CMD_TICK;
				w.now_ms = deadline + 32'(jitter);
			end
			default: begin
				if (steer || pick < 20) begin
					w.cmd = CMD_CONTROL;
					w.opcode = OP_HEARTBEAT;
					w.from_turbo = 1'b1;
					w.token_low = lease_lo;
					w.token_high = lease_hi;
					if (!steer && pick < 3) w.token_high ^= 64'd1 << $urandom_range(63);
				end else if (pick < 55) w.cmd = CMD_SUBMIT;
				else if (pick < 66) w.cmd = CMD_COMMIT;
				else if (pick < 74) w.cmd = CMD_FAULT;
				else if (pick < 94) begin
					// land near the heartbeat timeout, mostly just short of it
					w.cmd = CMD_TICK;
					w.now_ms = last_beat + {16'h0, cfg_timeout}
						+ 32'(int'($urandom_range(45)) - 40);
				end else begin
					w.cmd = CMD_CONTROL;
					w.opcode = OP_RELEASE;
					w.from_turbo = 1'b1;
					w.token_low = lease_lo;
					w.token_high = lease_hi;
				end
			end
		endcase
		clock_ms = w.now_ms;
		return w;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40) $display("MISMATCH word %0d: %s", words_seen, msg);
	endtask

	// Call just after a rising edge; returns at the edge that accepts the word.
	task automatic send_word(input req_word_t w, input bit typed, input logic [2:0] st,
			input logic [2:0] ev);
		rsp_word_t want;
		while ($urandom_range(99) < snd_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		want = lease_predict(w);
		if (typed) begin
			want.status = st;
			want.event_res = ev;
		end
		awaited_rsp.push_back(want);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		while (awaited_rsp.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_REENUM_DELAY: cfg_reenum = value;
			REG_LEASE_TIMEOUT: cfg_timeout = value;
			REG_NEUTRAL_DELAY: cfg_neutral = value;
			default: ;
		endcase
	endtask

	task automatic run_random(input int unsigned count);
		for (int unsigned n = 0; n < count; n++) begin
			if ($urandom_range(99) == 0) drain_results();
			send_word(next_item(1'b0), 1'b0, ST_OK, EV_NONE);
		end
	endtask

	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
	end

	always @(posedge clk) begin
		rsp_word_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			words_seen++;
			if (awaited_rsp.size() == 0) report_mismatch("result word with nothing expected");
			else begin
				want = awaited_rsp.pop_front();
				if (rsp.status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d", rsp.status, want.status));
				if (rsp.event_res !== want.event_res)
					report_mismatch($sformatf("event %0d, want %0d", rsp.event_res,
						want.event_res));
				if (rsp.mode_flags !== want.mode_flags)
					report_mismatch($sformatf("mode flags %h, want %h", rsp.mode_flags,
						want.mode_flags));
				if (rsp.rate_hz !== want.rate_hz)
					report_mismatch($sformatf("rate %0d, want %0d", rsp.rate_hz, want.rate_hz));
				if (rsp.sequence_res !== want.sequence_res)
					report_mismatch($sformatf("sequence %h, want %h", rsp.sequence_res,
						want.sequence_res));
				if (rsp.packet_flags !== want.packet_flags)
					report_mismatch($sformatf("packet flags %h, want %h", rsp.packet_flags,
						want.packet_flags));
				if (rsp.packet_made !== want.packet_made)
					report_mismatch($sformatf("packet made %b, want %b", rsp.packet_made,
						want.packet_made));
				if (rsp.overwrite_count !== want.overwrite_count)
					report_mismatch($sformatf("overwrites %0d, want %0d", rsp.overwrite_count,
						want.overwrite_count));
				if (rsp.fault_count !== want.fault_count)
					report_mismatch($sformatf("faults %0d, want %0d", rsp.fault_count,
						want.fault_count));
				if (rsp.lease_low !== want.lease_low)
					report_mismatch($sformatf("lease low %h, want %h", rsp.lease_low,
						want.lease_low));
				if (rsp.lease_high !== want.lease_high)
					report_mismatch($sformatf("lease high %h, want %h", rsp.lease_high,
						want.lease_high));
			end
		end
	end

	// end the run if neither channel moves a word for too long
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int unsigned steps;
		lease_clear();
		directed_rows.push_back('{ctl_word(OP_QUERY, 0, 1, 0, 0, 0, 0, 0), 1, ST_BAD_CRC, EV_NONE});
		directed_rows.push_back('{ctl_word(OP_QUERY, 1, 0, 1, 0, 0, 0, 0), 1, ST_BAD_VERSION,
			EV_NONE});
		directed_rows.push_back('{ctl_word(8'hFF, 1, 1, 0, 1, 0, 0, 0), 1, ST_BAD_STATE, EV_NONE});
		directed_rows.push_back('{ctl_word(OP_QUERY, 1, 1, 1, 0, 0, 0, 0), 1, ST_OK, EV_NONE});
		directed_rows.push_back('{ctl_word(OP_ACQUIRE, 1, 1, 1, 0, ALL_ONES, ALL_ONES, 0), 1,
			ST_BAD_STATE, EV_NONE});
		directed_rows.push_back('{ctl_word(OP_ACQUIRE, 1, 1, 1, 1, ALL_ONES, ALL_ONES, 0), 1,
			ST_BUSY, EV_NONE});
		directed_rows.push_back('{ctl_word(OP_HEARTBEAT, 1, 1, 1, 1, 0, 0, 0), 1, ST_BAD_STATE,
			EV_NONE});
		directed_rows.push_back('{ctl_word(OP_RELEASE, 1, 1, 1, 0, 0, 0, 0), 1, ST_BAD_STATE,
			EV_NONE});
		directed_rows.push_back('{evt_word(CMD_TICK, 0, 0, 0, 0), 1, ST_OK, EV_NONE});
		directed_rows.push_back('{evt_word(3'd6, '1, '1, 1, 1), 1, ST_OK, EV_NONE});
		directed_rows.push_back('{evt_word(CMD_SUBMIT, 1, 16'hFFFF, 1, 1), 0, ST_OK, EV_NONE});
		directed_rows.push_back('{ctl_word(OP_ACQUIRE, 1, 1, 1, 0, 0, 0, 0), 1, ST_BAD_STATE,
			EV_NONE});
		directed_rows.push_back('{ctl_word(OP_ACQUIRE, 1, 1, 0, 0, ALL_ONES, ALL_ONES, 0), 1,
			ST_BAD_STATE, EV_NONE});
		directed_rows.push_back('{ctl_word(OP_ACQUIRE, 1, 1, 1, 0, ALL_ONES, ALL_ONES, 2), 1,
			ST_OK, EV_NONE});
		directed_rows.push_back('{evt_word(CMD_TICK, 5, 0, 0, 0), 1, ST_OK, EV_SEND_NEUTRAL});
		// neutral delay pushes the deadline across the wrap to 4
		directed_rows.push_back('{evt_word(CMD_NEUTRAL, 32'hFFFF_FFF0, 0, 0, 0), 0, ST_OK,
			EV_NONE});
		directed_rows.push_back('{evt_word(CMD_TICK, 32'hFFFF_FFFF, 0, 0, 0), 1, ST_OK, EV_NONE});
		directed_rows.push_back('{evt_word(CMD_TICK, 4, 0, 0, 0), 1, ST_OK, EV_DETACH_TURBO});
		directed_rows.push_back('{evt_word(CMD_TICK, 104, 0, 0, 0), 1, ST_OK, EV_ATTACH_TURBO});
		directed_rows.push_back('{ctl_word(OP_HEARTBEAT, 1, 1, 1, 1, 0, ALL_ONES, 150), 1,
			ST_BAD_TOKEN, EV_NONE});
		directed_rows.push_back('{ctl_word(OP_HEARTBEAT, 1, 1, 1, 1, ALL_ONES, ALL_ONES, 200), 1,
			ST_OK, EV_NONE});
		directed_rows.push_back('{evt_word(CMD_SUBMIT, 210, 16'h0000, 0, 0), 0, ST_OK, EV_NONE});
		directed_rows.push_back('{evt_word(CMD_SUBMIT, 211, 16'd5000, 1, 1), 0, ST_OK, EV_NONE});
		directed_rows.push_back('{evt_word(CMD_COMMIT, 212, 0, 0, 0), 0, ST_OK, EV_NONE});
		directed_rows.push_back('{evt_word(CMD_FAULT, 213, 0, 0, 0), 0, ST_OK, EV_NONE});
		directed_rows.push_back('{evt_word(CMD_TICK, 700, 0, 0, 0), 1, ST_OK, EV_DETACH_NATIVE});
		directed_rows.push_back('{evt_word(CMD_TICK, 800, 0, 0, 0), 1, ST_OK, EV_ATTACH_NATIVE});

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].status,
				directed_rows[i].event_res);

		// low extremes, zero lease timeout included
		drain_results();
		write_reg(REG_REENUM_DELAY, 16'd0);
		write_reg(REG_LEASE_TIMEOUT, 16'd0);
		write_reg(REG_NEUTRAL_DELAY, 16'd0);
		clock_ms = $urandom;
		run_random(330);

		// high extremes, starting just short of the time wrap
		drain_results();
		snd_idle_pct = 50;
		rcv_idle_pct = 24;
		write_reg(REG_REENUM_DELAY, 16'hFFFF);
		write_reg(REG_LEASE_TIMEOUT, 16'hFFFF);
		write_reg(REG_NEUTRAL_DELAY, 16'hFFFF);
		clock_ms = 32'hFFFF_FF00;
		run_random(330);

		drain_results();
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		write_reg(REG_REENUM_DELAY, 16'($urandom_range(300, 1)));
		write_reg(REG_LEASE_TIMEOUT, 16'($urandom_range(300, 1)));
		write_reg(REG_NEUTRAL_DELAY, 16'($urandom_range(300, 1)));
		run_random(330);

		// walk into turbo active, then stack up overwrites and link faults
		steps = 0;
		while (lease_mode != M_TURBO_ACTIVE && steps < 50) begin
			send_word(next_item(1'b1), 1'b0, ST_OK, EV_NONE);
			steps++;
		end
		repeat (8)
			send_word(evt_word(CMD_SUBMIT, clock_ms, 16'($urandom_range(65535)),
				1'($urandom_range(1)), 1'($urandom_range(1))), 1'b0, ST_OK, EV_NONE);
		repeat (8)
			send_word(evt_word(CMD_FAULT, clock_ms, 16'd0, 0, 0), 1'b0, ST_OK, EV_NONE);

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// File: files.f
sv/urlc_pkg.sv
sv/urlc_lease_fsm.sv
sv/usb_rate_lease_controller.sv
sv/urlc_checker.sv
test/tb_usb_rate_lease_controller.sv
